// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker in ppcf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ppcf_pkg.sv =====
`timescale 1ns / 1ps

package ppcf_pkg;

  // Field widths
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned COLOR_INDEX_W = 8;
  localparam int unsigned RGB_W         = 3 * CHAN_W;
  localparam int unsigned IN_DATA_W     = COLOR_INDEX_W + RGB_W;
  localparam int unsigned OUT_DATA_W    = RGB_W;
  localparam int unsigned MODE_W        = 2;

  // Palette depth default
  localparam int unsigned PALETTE_ENTRIES_DEF = 256;

  // Luminance weights, sum is 256
  localparam int unsigned LUM_R_COEF = 77;
  localparam int unsigned LUM_G_COEF = 150;
  localparam int unsigned LUM_B_COEF = 29;
  localparam int unsigned LUM_SUM_W  = 16;

  // Item kind carried on tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE    = 2'd0,
    MODE_THERMAL = 2'd1,
    MODE_SYNTH   = 2'd2,
    MODE_MATRIX  = 2'd3
  } filter_mode_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t rgb;
    logic last;
  } pixel_res_t;

endpackage

// ===== rtl/core/palette_pixel_color_filter_top.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Signals                        | Content
// in_      | in  | tvalid tready tdata tuser tlast | palette write or pixel lookup
// out_     | out | tvalid tready tdata tlast       | filtered RGB pixel
// cfg_     | in  | we wdata                        | filter_mode register
// One transaction accepted per clock while in_tready is high; pixels pass stages 1 to 3
// and the output register. Palette memory: one write port, one registered read port.
// rst_n (synchronous) clears the pipeline, output and skid valids and the mode.
// The palette contents are undefined until written; reset does not clear them.
// in_tready falls only while the skid register holds a result that out_ has not taken.

module palette_pixel_color_filter_top #(
  parameter int unsigned PALETTE_ENTRIES = ppcf_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: color_index, entry_red, entry_green, entry_blue
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ppcf_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: func
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  // out_tdata: pixel_red, pixel_green, pixel_blue
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ppcf_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [ppcf_pkg::MODE_W-1:0]      cfg_wdata
);
  import ppcf_pkg::*;

  localparam int unsigned IDX_W   = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CMP_W   = COLOR_INDEX_W + 1;
  localparam int unsigned PROD_W  = 16;
  localparam int unsigned MAT_W   = 18;

  // Divide by 255, exact for x below 65280
  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] s;
    s = {1'b0, x} + {9'd0, x[PROD_W-1:8]} + 17'd1;
    return s[PROD_W-1:8];
  endfunction

  // Input unpacking
  logic [COLOR_INDEX_W-1:0] in_idx;
  rgb_t                     in_rgb;
  logic                     in_range;
  logic                     en;
  logic                     skid_v_r;

  assign in_idx   = in_tdata[COLOR_INDEX_W-1:0];
  assign in_rgb   = '{red:   in_tdata[COLOR_INDEX_W +: CHAN_W],
                      green: in_tdata[COLOR_INDEX_W + CHAN_W +: CHAN_W],
                      blue:  in_tdata[COLOR_INDEX_W + 2*CHAN_W +: CHAN_W]};
  assign in_range = (CMP_W'(in_idx) < CMP_W'(PALETTE_ENTRIES));

  // Pipeline moves whenever the skid register is free
  assign en        = 1'b1 ^ skid_v_r;
  assign in_tready = en;

  // Mode register
  filter_mode_t mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
    end else if (cfg_we) begin
      mode_r <= filter_mode_t'(cfg_wdata);
    end
  end

  // Palette memory
  logic [RGB_W-1:0] pal_mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (in_tvalid && en && (in_tuser == FUNC_WRITE) && in_range) begin
      pal_mem[in_idx[IDX_W-1:0]] <= in_rgb;
    end
  end

  // Stage 1: palette read
  logic [RGB_W-1:0] s1_rd_r;
  logic             s1_range_r;
  logic             s1_last_r;
  logic             s1_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rd_r    <= pal_mem[in_idx[IDX_W-1:0]];
      s1_range_r <= in_range;
      s1_last_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid && (in_tuser == FUNC_PIXEL);
    end
  end

  // Stage 2: luminance weighted sum
  rgb_t                 s1_rgb;
  logic [LUM_SUM_W-1:0] s2_sum_nxt;
  logic [LUM_SUM_W-1:0] s2_sum_r;
  rgb_t                 s2_rgb_r;
  logic                 s2_last_r;
  logic                 s2_v_r;

  // Out-of-range index reads black
  assign s1_rgb = s1_range_r ? rgb_t'(s1_rd_r) : '0;

  assign s2_sum_nxt = LUM_SUM_W'(s1_rgb.red)   * LUM_SUM_W'(LUM_R_COEF)
                    + LUM_SUM_W'(s1_rgb.green) * LUM_SUM_W'(LUM_G_COEF)
                    + LUM_SUM_W'(s1_rgb.blue)  * LUM_SUM_W'(LUM_B_COEF);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sum_r  <= s2_sum_nxt;
      s2_rgb_r  <= s1_rgb;
      s2_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  // Stage 3: ramp products, thermal and green monochrome
  logic [CHAN_W-1:0] lum;
  logic              lum_hi;
  logic [CHAN_W-1:0] ramp_t;
  logic [CHAN_W-1:0] ka, kb, kc;
  rgb_t              therm_nxt;
  rgb_t              mat_nxt;
  logic [9:0]        tri3;
  logic [CHAN_W:0]   mat_g;
  logic [MAT_W-1:0]  mat_r6;
  logic [MAT_W-1:0]  mat_b5;

  assign lum    = s2_sum_r[LUM_SUM_W-1:8];
  assign lum_hi = lum[CHAN_W-1];
  assign ramp_t = {lum[CHAN_W-2:0], 1'b0};
  assign ka     = lum_hi ? 8'd255 : 8'd235;
  assign kb     = lum_hi ? 8'd210 : 8'd20;
  assign kc     = lum_hi ? 8'd108 : 8'd107;

  // Thermal ramp
  always_comb begin
    therm_nxt = '0;
    if (lum < 8'd85) begin
      tri3          = 10'(lum) * 10'd3;
      therm_nxt.red = tri3[CHAN_W-1:0];
    end else if (lum < 8'd170) begin
      tri3            = 10'(lum - 8'd85) * 10'd3;
      therm_nxt.red   = 8'd255;
      therm_nxt.green = tri3[CHAN_W-1:0];
    end else begin
      tri3            = 10'(lum - 8'd170) * 10'd3;
      therm_nxt.red   = 8'd255;
      therm_nxt.green = 8'd255;
      therm_nxt.blue  = tri3[CHAN_W-1:0];
    end
  end

  // Green monochrome: lum/6 and lum/5 by reciprocal, green saturates
  assign mat_r6 = MAT_W'(lum) * MAT_W'(171);
  assign mat_b5 = MAT_W'(lum) * MAT_W'(205);
  assign mat_g  = (CHAN_W+1)'(lum) + (CHAN_W+1)'(lum >> 3);
  assign mat_nxt = '{red:   mat_r6[17:10],
                     green: mat_g[CHAN_W] ? 8'd255 : mat_g[CHAN_W-1:0],
                     blue:  mat_b5[17:10]};

  logic [PROD_W-1:0] s3_pa_r, s3_pb_r, s3_pc_r;
  logic              s3_hi_r;
  rgb_t              s3_rgb_r;
  rgb_t              s3_therm_r;
  rgb_t              s3_mat_r;
  logic              s3_last_r;
  logic              s3_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pa_r    <= PROD_W'(ramp_t) * PROD_W'(ka);
      s3_pb_r    <= PROD_W'(ramp_t) * PROD_W'(kb);
      s3_pc_r    <= PROD_W'(ramp_t) * PROD_W'(kc);
      s3_hi_r    <= lum_hi;
      s3_rgb_r   <= s2_rgb_r;
      s3_therm_r <= therm_nxt;
      s3_mat_r   <= mat_nxt;
      s3_last_r  <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  // Stage 4: synthwave scaling and mode select
  logic [CHAN_W-1:0] qa, qb, qc;
  rgb_t              synth;
  pixel_res_t        res;

  assign qa = div255(s3_pa_r);
  assign qb = div255(s3_pb_r);
  assign qc = div255(s3_pc_r);

  always_comb begin
    if (s3_hi_r) begin
      synth = '{red: 8'd255 - qa, green: 8'd20 + qb, blue: 8'd147 + qc};
    end else begin
      synth = '{red: 8'd20 + qa, green: qb, blue: 8'd40 + qc};
    end
  end

  always_comb begin
    res.last = s3_last_r;
    unique case (mode_r)
      MODE_NONE:    res.rgb = s3_rgb_r;
      MODE_THERMAL: res.rgb = s3_therm_r;
      MODE_SYNTH:   res.rgb = synth;
      MODE_MATRIX:  res.rgb = s3_mat_r;
    endcase
  end

  // Output register with skid
  pixel_res_t out_r, skid_r;
  logic       out_v_r;
  logic       out_take;

  assign out_take = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        out_r    <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (s3_v_r) begin
      if (!out_v_r || out_take) begin
        out_r   <= res;
        out_v_r <= 1'b1;
      end else begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.rgb.blue, out_r.rgb.green, out_r.rgb.red};
  assign out_tlast  = out_r.last;

endmodule

// ===== rtl/core/ppcf_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppcf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [ppcf_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic                             in_tuser,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ppcf_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tlast,
  input logic                             cfg_we,
  input logic [ppcf_pkg::MODE_W-1:0]      cfg_wdata
);
  import ppcf_pkg::*;

  // A stalled result holds its data
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "out_ transaction changed while stalled")

  // Input back-pressure only while a result is waiting on the output
  `ASSERT_CLK(a_stall_cause, clk, rst_n, !in_tready |-> out_tvalid, "in_tready low with no pending result")

  // With a free-running sink an accepted pixel reaches out_ through the stage and output registers
  `ASSERT_CLK(a_latency, clk, rst_n, (in_tvalid && in_tready && (in_tuser == FUNC_PIXEL) && out_tready) ##1 out_tready ##1 out_tready |=> ##1 out_tvalid, "pixel result missing after pipeline latency")

  // Reset empties the pipeline and opens the input
  `ASSERT_CLK_RST(a_reset, clk, !rst_n |=> !out_tvalid && in_tready, "state not cleared by reset")

endmodule

bind palette_pixel_color_filter_top ppcf_checker u_ppcf_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ppcf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 6;     // pipeline depth, allow margin
  localparam int unsigned HOLD_CYCLES = 80;     // long receiver hold-off
  localparam int unsigned PHASE_ITEMS = 100;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // color_index, entry_red, entry_green, entry_blue
  logic                  in_tuser;   // func
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // pixel_red, pixel_green, pixel_blue
  logic                  out_tlast;
  logic                  cfg_we;
  logic [MODE_W-1:0]     cfg_wdata;

  // Directed stimulus row; exp_* only used where typed is set
  typedef struct {
    filter_mode_t mode;
    logic         func;
    logic [7:0]   idx;
    rgb_t         colour;
    logic         last;
    bit           typed;
    rgb_t         exp_colour;
  } stim_row_t;

  stim_row_t    stim_rows[$];
  pixel_res_t   pending_pixels[$];
  rgb_t         palette_copy[256];
  bit           entry_written[256];
  int           written_idx[$];
  filter_mode_t mode_copy;
  int unsigned  send_idle;
  int unsigned  recv_idle;
  int unsigned  cycle_count;
  int unsigned  error_count;
  logic         hold_armed;

  palette_pixel_color_filter_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Saturate a channel to 0..255
  function automatic logic [7:0] sat_chan(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Colour filter applied to one palette entry
  function automatic rgb_t filter_colour(rgb_t c, filter_mode_t m);
    int   lum;
    int   t;
    int   r;
    int   g;
    int   b;
    rgb_t res;
    lum = (LUM_R_COEF * int'(c.red) + LUM_G_COEF * int'(c.green)
           + LUM_B_COEF * int'(c.blue)) >> 8;
    r = c.red;
    g = c.green;
    b = c.blue;
    case (m)
      MODE_THERMAL: begin
        if (lum < 85) begin
          r = 3 * lum; g = 0; b = 0;
        end else if (lum < 170) begin
          r = 255; g = 3 * (lum - 85); b = 0;
        end else begin
          r = 255; g = 255; b = 3 * (lum - 170);
        end
      end
      MODE_SYNTH: begin
        if (lum < 128) begin
          t = 2 * lum;
          r = 20 + t * 235 / 255;
          g = t * 20 / 255;
          b = 40 + t * 107 / 255;
        end else begin
          t = 2 * (lum - 128);
          r = 255 - t * 255 / 255;
          g = 20 + t * 210 / 255;
          b = 147 + t * 108 / 255;
        end
      end
      MODE_MATRIX: begin
        r = lum / 6;
        g = lum + (lum >> 3);
        b = lum / 5;
      end
      default: ;
    endcase
    res.red   = sat_chan(r);
    res.green = sat_chan(g);
    res.blue  = sat_chan(b);
    return res;
  endfunction

  task automatic add_row(filter_mode_t m, logic func, logic [7:0] idx, rgb_t c, logic last,
                         bit typed, rgb_t ec);
    stim_row_t row;
    row.mode = m;
    row.func = func;
    row.idx = idx;
    row.colour = c;
    row.last = last;
    row.typed = typed;
    row.exp_colour = ec;
    stim_rows.push_back(row);
  endtask

  // Offer one transaction after a random gap; returns once it is accepted
  task automatic offer_item(logic func, logic [7:0] idx, rgb_t c, logic last);
    int gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tlast  <= last;
    in_tdata  <= {c.blue, c.green, c.red, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  // Update the palette copy, or queue the filtered pixel
  task automatic note_item(logic func, logic [7:0] idx, rgb_t c, logic last);
    pixel_res_t px;
    if (func == FUNC_WRITE) begin
      palette_copy[idx] = c;
      if (!entry_written[idx]) begin
        entry_written[idx] = 1'b1;
        written_idx.push_back(idx);
      end
    end else begin
      px.rgb  = filter_colour(palette_copy[idx], mode_copy);
      px.last = last;
      pending_pixels.push_back(px);
    end
  endtask

  // Wait until the pipe is empty, then write the filter mode
  task automatic set_filter(filter_mode_t m);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mode_copy = m;
  endtask

  // Receiver: random ready, one long hold-off on request, result checking
  always @(posedge clk) begin
    int unsigned hold_left;
    bit          hold_done;
    pixel_res_t  exp_px;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel transaction: tdata %h tlast %b", out_tdata, out_tlast);
          error_count++;
        end else begin
          exp_px = pending_pixels.pop_front();
          if (out_tdata[7:0] !== exp_px.rgb.red) begin
            $error("pixel_red: expected %0d, got %0d", exp_px.rgb.red, out_tdata[7:0]);
            error_count++;
          end
          if (out_tdata[15:8] !== exp_px.rgb.green) begin
            $error("pixel_green: expected %0d, got %0d", exp_px.rgb.green, out_tdata[15:8]);
            error_count++;
          end
          if (out_tdata[23:16] !== exp_px.rgb.blue) begin
            $error("pixel_blue: expected %0d, got %0d", exp_px.rgb.blue, out_tdata[23:16]);
            error_count++;
          end
          if (out_tlast !== exp_px.last) begin
            $error("frame_end: expected %0b, got %0b", exp_px.last, out_tlast);
            error_count++;
          end
        end
      end
      if (hold_armed && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    rgb_t       c;
    rgb_t       blank;
    logic       func;
    logic [7:0] idx;
    logic       last;
    bit         mode_set;
    pixel_res_t px;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= FUNC_WRITE;
    in_tlast    <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= MODE_NONE;
    hold_armed  <= 1'b0;
    cycle_count = 0;
    error_count = 0;
    mode_copy   = MODE_NONE;
    mode_set    = 1'b0;
    send_idle   = 15;
    recv_idle   = 65;
    blank       = '0;

    // Directed table: entries with black, white, a mixed colour and greys on
    // either side of the thermal and synthwave luminance thresholds
    add_row(MODE_NONE, FUNC_WRITE, 8'd0,   rgb_t'(24'h000000), 1'b0, 1'b0, blank);
    add_row(MODE_NONE, FUNC_WRITE, 8'd255, rgb_t'(24'hFFFFFF), 1'b0, 1'b0, blank);
    add_row(MODE_NONE, FUNC_WRITE, 8'd1,   rgb_t'(24'h804020), 1'b1, 1'b0, blank);
    add_row(MODE_NONE, FUNC_WRITE, 8'd2,   rgb_t'(24'h646464), 1'b0, 1'b0, blank);
    add_row(MODE_NONE, FUNC_WRITE, 8'd3,   rgb_t'(24'hC8C8C8), 1'b0, 1'b0, blank);
    add_row(MODE_NONE, FUNC_WRITE, 8'd4,   rgb_t'(24'h323232), 1'b0, 1'b0, blank);
    add_row(MODE_NONE, FUNC_WRITE, 8'd5,   rgb_t'(24'h7F7F7F), 1'b0, 1'b0, blank);
    add_row(MODE_NONE, FUNC_WRITE, 8'd6,   rgb_t'(24'h808080), 1'b0, 1'b0, blank);
    // pass-through
    add_row(MODE_NONE, FUNC_PIXEL, 8'd0,   blank, 1'b0, 1'b1, rgb_t'(24'h000000));
    add_row(MODE_NONE, FUNC_PIXEL, 8'd255, blank, 1'b1, 1'b1, rgb_t'(24'hFFFFFF));
    add_row(MODE_NONE, FUNC_PIXEL, 8'd1,   blank, 1'b0, 1'b1, rgb_t'(24'h804020));
    // thermal: ends typed, the three bands predicted
    add_row(MODE_THERMAL, FUNC_PIXEL, 8'd0,   blank, 1'b0, 1'b1, rgb_t'(24'h000000));
    add_row(MODE_THERMAL, FUNC_PIXEL, 8'd255, blank, 1'b1, 1'b1, rgb_t'(24'hFFFFFF));
    add_row(MODE_THERMAL, FUNC_PIXEL, 8'd4,   blank, 1'b0, 1'b0, blank);
    add_row(MODE_THERMAL, FUNC_PIXEL, 8'd2,   blank, 1'b0, 1'b0, blank);
    add_row(MODE_THERMAL, FUNC_PIXEL, 8'd3,   blank, 1'b1, 1'b0, blank);
    // synthwave: black gives the ramp base, then both halves
    add_row(MODE_SYNTH, FUNC_PIXEL, 8'd0,   blank, 1'b0, 1'b1, rgb_t'({8'd20, 8'd0, 8'd40}));
    add_row(MODE_SYNTH, FUNC_PIXEL, 8'd255, blank, 1'b0, 1'b0, blank);
    add_row(MODE_SYNTH, FUNC_PIXEL, 8'd5,   blank, 1'b0, 1'b0, blank);
    add_row(MODE_SYNTH, FUNC_PIXEL, 8'd6,   blank, 1'b1, 1'b0, blank);
    // green monochrome: white saturates the green channel
    add_row(MODE_MATRIX, FUNC_PIXEL, 8'd0,   blank, 1'b0, 1'b1, rgb_t'(24'h000000));
    add_row(MODE_MATRIX, FUNC_PIXEL, 8'd255, blank, 1'b0, 1'b1, rgb_t'({8'd42, 8'd255, 8'd51}));
    add_row(MODE_MATRIX, FUNC_PIXEL, 8'd1,   blank, 1'b1, 1'b0, blank);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    foreach (stim_rows[i]) begin
      if (!mode_set || stim_rows[i].mode != mode_copy) begin
        set_filter(stim_rows[i].mode);
        mode_set = 1'b1;
      end
      offer_item(stim_rows[i].func, stim_rows[i].idx, stim_rows[i].colour, stim_rows[i].last);
      if (stim_rows[i].typed && stim_rows[i].func == FUNC_PIXEL) begin
        px.rgb  = stim_rows[i].exp_colour;
        px.last = stim_rows[i].last;
        pending_pixels.push_back(px);
      end else begin
        note_item(stim_rows[i].func, stim_rows[i].idx, stim_rows[i].colour, stim_rows[i].last);
      end
    end

    // Random part: six phases, three idling patterns, every filter mode
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 4) set_filter(filter_mode_t'(phase));
      else set_filter(filter_mode_t'($urandom_range(3)));
      send_idle = (phase < 2) ? 15 : (phase < 4) ? 65 : 0;
      recv_idle = (phase < 2) ? 65 : (phase < 4) ? 15 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver stall while the sender keeps going
        if (phase == 4 && n == 30) hold_armed <= 1'b1;
        c = rgb_t'(24'($urandom));
        last = ($urandom_range(7) == 0);
        if ($urandom_range(99) < 30) begin
          func = FUNC_WRITE;
          idx = 8'($urandom_range(255));
        end else begin
          // pixels only ever read entries that were written
          func = FUNC_PIXEL;
          idx = 8'(written_idx[$urandom_range(written_idx.size() - 1)]);
        end
        offer_item(func, idx, c, last);
        note_item(func, idx, c, last);
      end
    end

    // Drain and finish
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ppcf_pkg.sv
rtl/core/palette_pixel_color_filter_top.sv
rtl/core/ppcf_checker.sv
bench/testbench.sv
